[sv/slt_pkg.sv]
package slt_pkg;

    // Text limits: the position counter stops at the smaller of the text size minus one
    // and the 16-bit range
    localparam int unsigned MAX_TEXT = 65536;
    localparam logic [15:0] POS_CAP  = 16'((MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1);
    localparam logic [15:0] LEN_CAP  = 16'hFFFF;

    // Default number of identifier bytes kept for keyword matching
    localparam int unsigned KW_CHARS_DEFAULT = 5;
    localparam int unsigned KW_WORD_W        = 40;
    localparam int unsigned KW_COUNT         = 7;
    localparam int unsigned OP_COUNT         = 9;

    // Token kinds
    localparam logic [4:0] KIND_NUMBER   = 5'd0;
    localparam logic [4:0] KIND_IDENT    = 5'd1;
    localparam logic [4:0] KIND_STRING   = 5'd2;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd3;
    localparam logic [4:0] KIND_OP0      = 5'd10;
    localparam logic [4:0] KIND_NEWLINE  = 5'd19;
    localparam logic [4:0] KIND_UNKNOWN  = 5'd20;
    localparam logic [4:0] KIND_END      = 5'd21;

    // Characters with a role of their own
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    // Keywords packed first byte lowest: print let trace times read rand sleep
    localparam logic [KW_WORD_W-1:0] KW_TEXT [KW_COUNT] = '{
        40'h746E697270,
        40'h000074656C,
        40'h6563617274,
        40'h73656D6974,
        40'h0064616572,
        40'h00646E6172,
        40'h7065656C73
    };
    localparam logic [15:0] KW_LEN [KW_COUNT] = '{
        16'd5, 16'd3, 16'd5, 16'd5, 16'd4, 16'd4, 16'd5
    };

    // Operators in kind order: + - * / % ( ) = ;
    localparam logic [7:0] OP_CHARS [OP_COUNT] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h28, 8'h29, 8'h3D, 8'h3B
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  ubyte;
        logic        last;
    } token_t;

    // Results of one scanned byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_res_t;

endpackage

[sv/slt_if.sv]
interface slt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface slt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] value_len;
    logic [7:0]  unknown_byte;
    logic        last;

    modport source (output valid, output token_kind, output start_pos, output value_len,
                    output unknown_byte, output last, input ready);
    modport sink   (input valid, input token_kind, input start_pos, input value_len,
                    input unknown_byte, input last, output ready);
endinterface

[sv/script_lexer_token_stream.sv]
// An accepted byte is held in the input register; its scan result is then registered in
// the result queue. Throughput: one byte per cycle while each byte gives at most one
// token and the token port is ready; a byte that gives two tokens (a flush plus its own
// token, or a flush plus the end token) holds the next byte until the second is taken.
// Reset: rst_n asynchronous active low; empties both stages and starts a new text at 0.
module script_lexer_token_stream
    import slt_pkg::*;
#(
    parameter int unsigned KEYWORD_CHARS = KW_CHARS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    slt_in_if.sink    text,
    slt_out_if.source tokens
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       eot_reg;
    logic       accept;
    logic       advance;
    logic       space;
    scan_res_t  res;

    // Take a byte when the input register is empty or drains this cycle
    assign advance    = in_valid_reg && space;
    assign text.ready = !in_valid_reg || advance;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text.text_byte;
            eot_reg  <= text.end_of_text;
        end
    end

    slt_scan #(
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .res         (res)
    );

    slt_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (advance),
        .res    (res),
        .space  (space),
        .tokens (tokens)
    );

endmodule

[sv/slt_scan.sv]
module slt_scan
    import slt_pkg::*;
#(
    parameter int unsigned KEYWORD_CHARS = KW_CHARS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output scan_res_t  res
);

    localparam int unsigned PFX_W = 8 * KEYWORD_CHARS;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_STRING
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [15:0]      pos_reg, pos_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      len_reg, len_next;
    logic [PFX_W-1:0] prefix_reg, prefix_next;
    logic             dot_reg, dot_next;

    logic        ended;
    logic        is_digit, is_letter;
    logic [4:0]  ident_kind;
    token_t      pend_tok, fresh_tok, end_tok;
    logic        flush_emit, fresh, fresh_emit;
    logic [15:0] len_grown;

    // Classify the byte
    always_comb
    begin
        ended     = end_of_text || (text_byte == CH_NUL);
        is_digit  = text_byte inside {[8'h30:8'h39]};
        is_letter = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        len_grown = (len_reg < LEN_CAP) ? len_reg + 16'd1 : len_reg;
    end

    // Match the pending identifier against the keyword table
    always_comb
    begin
        ident_kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (len_reg == KW_LEN[i] && prefix_reg == PFX_W'(KW_TEXT[i]))
            begin
                ident_kind = KIND_KEYWORD0 + 5'(i);
            end
        end
    end

    // Build the pending token and the end token
    always_comb
    begin
        pend_tok.start = start_reg;
        pend_tok.len   = len_reg;
        pend_tok.ubyte = 8'h00;
        pend_tok.last  = 1'b0;
        case (mode_reg)
            MODE_NUMBER: pend_tok.kind = KIND_NUMBER;
            MODE_IDENT:  pend_tok.kind = ident_kind;
            MODE_STRING: pend_tok.kind = KIND_STRING;
            default:     pend_tok.kind = KIND_NUMBER;
        endcase

        end_tok.kind  = KIND_END;
        end_tok.start = pos_reg;
        end_tok.len   = 16'd0;
        end_tok.ubyte = 8'h00;
        end_tok.last  = 1'b1;
    end

    // Advance the scan: continue the pending token or lex the byte afresh
    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        dot_next    = dot_reg;
        flush_emit  = 1'b0;
        fresh       = 1'b0;
        fresh_emit  = 1'b0;

        fresh_tok.kind  = KIND_UNKNOWN;
        fresh_tok.start = pos_reg;
        fresh_tok.len   = 16'd1;
        fresh_tok.ubyte = text_byte;
        fresh_tok.last  = 1'b0;

        case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    len_next = len_grown;
                end
                else if (text_byte == CH_DOT && !dot_reg)
                begin
                    dot_next = 1'b1;
                    len_next = len_grown;
                end
                else
                begin
                    flush_emit = 1'b1;
                    mode_next  = MODE_IDLE;
                    fresh      = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_letter || is_digit || text_byte == CH_USCORE)
                begin
                    for (int b = 0; b < KEYWORD_CHARS; b++)
                    begin
                        if (len_reg == 16'(b))
                        begin
                            prefix_next[8*b +: 8] = text_byte;
                        end
                    end
                    len_next = len_grown;
                end
                else
                begin
                    flush_emit = 1'b1;
                    mode_next  = MODE_IDLE;
                    fresh      = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    flush_emit = 1'b1;
                    mode_next  = MODE_IDLE;
                end
                else
                begin
                    len_next = len_grown;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // Start a token, emit a one-byte token, or skip a blank
        if (fresh)
        begin
            if (text_byte == CH_SPACE || text_byte == CH_TAB || text_byte == CH_CR)
            begin
                fresh_emit = 1'b0;
            end
            else if (text_byte == CH_NL)
            begin
                fresh_emit      = 1'b1;
                fresh_tok.kind  = KIND_NEWLINE;
                fresh_tok.ubyte = 8'h00;
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = 16'd1;
                dot_next   = 1'b0;
            end
            else if (is_letter)
            begin
                mode_next   = MODE_IDENT;
                start_next  = pos_reg;
                len_next    = 16'd1;
                prefix_next = PFX_W'(text_byte);
            end
            else if (text_byte == CH_QUOTE)
            begin
                mode_next  = MODE_STRING;
                start_next = pos_reg;
                len_next   = 16'd0;
            end
            else
            begin
                fresh_emit = 1'b1;
                for (int i = 0; i < OP_COUNT; i++)
                begin
                    if (text_byte == OP_CHARS[i])
                    begin
                        fresh_tok.kind  = KIND_OP0 + 5'(i);
                        fresh_tok.ubyte = 8'h00;
                    end
                end
            end
        end

        pos_next = (pos_reg < POS_CAP) ? pos_reg + 16'd1 : pos_reg;

        // End of text: flush, emit the end token, return to the reset state
        if (ended)
        begin
            mode_next   = MODE_IDLE;
            pos_next    = 16'd0;
            start_next  = 16'd0;
            len_next    = 16'd0;
            prefix_next = '0;
            dot_next    = 1'b0;
        end
    end

    // Order the results: the pending token always goes first
    always_comb
    begin
        if (ended)
        begin
            res.count  = (mode_reg != MODE_IDLE) ? 2'd2 : 2'd1;
            res.first  = (mode_reg != MODE_IDLE) ? pend_tok : end_tok;
            res.second = end_tok;
        end
        else if (flush_emit)
        begin
            res.count  = (fresh && fresh_emit) ? 2'd2 : 2'd1;
            res.first  = pend_tok;
            res.second = fresh_tok;
        end
        else
        begin
            res.count  = (fresh && fresh_emit) ? 2'd1 : 2'd0;
            res.first  = fresh_tok;
            res.second = fresh_tok;
        end
    end

    // Hold the scan state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= 16'd0;
            start_reg  <= 16'd0;
            len_reg    <= 16'd0;
            prefix_reg <= '0;
            dot_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            dot_reg    <= dot_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ended |=> pos_reg == 16'd0 && mode_reg == MODE_IDLE)
        else $error("scan state not cleared after end of text");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !ended && pos_reg < POS_CAP |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position did not advance");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.count == 2'd2 |-> !res.first.last && res.first.kind != KIND_END)
        else $error("end token placed ahead of a flushed token");

endmodule

[sv/slt_outq.sv]
module slt_outq
    import slt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  scan_res_t        res,
    output logic             space,
    slt_out_if.source        tokens
);

    token_t     slot0_reg, slot0_next;
    token_t     slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    // Present the head slot
    assign tokens.valid        = (count_reg != 2'd0);
    assign tokens.token_kind   = slot0_reg.kind;
    assign tokens.start_pos    = slot0_reg.start;
    assign tokens.value_len    = slot0_reg.len;
    assign tokens.unknown_byte = slot0_reg.ubyte;
    assign tokens.last         = slot0_reg.last;

    assign pop   = tokens.valid && tokens.ready;
    assign space = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);

    // Load a new pair when drained, else shift on each transaction
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push)
        begin
            slot0_next = res.first;
            slot1_next = res.second;
            count_next = res.count;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_push_drained: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg == 2'd0 || (count_reg == 2'd1 && pop))
        else $error("results loaded over undelivered tokens");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 2'd1)
        else $error("result queue lost track of a delivered token");

endmodule

[tb/testbench.sv]
module testbench
    import slt_pkg::*;
();

    localparam int unsigned KW_CHARS     = KW_CHARS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned RANDOM_BYTES = 560;
    localparam int unsigned LONG_STRING  = 200;
    localparam int unsigned OP_NUM       = 9;
    localparam int unsigned KW_NUM       = 7;

    // Operator characters in kind order, leftmost in the top byte
    localparam logic [8*OP_NUM-1:0] OP_TEXT = "+-*/%()=;";

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_STRING} scan_mode_e;
    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_COIN, RX_BLOCKS} rx_pattern_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_eot    = 1'b0;
    logic        in_taken  = 1'b0;
    logic        out_ready = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    logic [31:0] ready_tick = '0;
    rx_pattern_e rx_pattern = RX_OPEN;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;

    text_item_t pending_q [$];
    token_t     token_expect_q [$];

    // Lexer prediction state
    scan_mode_e  lex_mode   = SCAN_IDLE;
    logic [15:0] lex_pos    = '0;
    logic [15:0] lex_start  = '0;
    logic [15:0] lex_len    = '0;
    logic [39:0] lex_prefix = '0;
    logic        lex_dot    = 1'b0;

    slt_in_if  text_ch ();
    slt_out_if token_ch ();

    assign text_ch.valid       = in_valid;
    assign text_ch.text_byte   = in_byte;
    assign text_ch.end_of_text = in_eot;
    assign token_ch.ready      = out_ready;

    script_lexer_token_stream uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch)
    );

    always #5 clk = ~clk;

    function automatic string keyword_word(int idx);
        case (idx)
            0:       return "print";
            1:       return "let";
            2:       return "trace";
            3:       return "times";
            4:       return "read";
            5:       return "rand";
            default: return "sleep";
        endcase
    endfunction

    function automatic logic is_digit(logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic void expect_token(logic [4:0] kind, logic [15:0] start,
                                         logic [15:0] len, logic [7:0] ub, logic lst);
        token_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.ubyte = ub;
        t.last  = lst;
        token_expect_q.insert(token_expect_q.size(), t);
    endfunction

    // Match a finished identifier against the keyword list
    function automatic logic [4:0] ident_kind();
        string       w;
        logic [39:0] packed_w;
        logic [4:0]  kind;
        kind = KIND_IDENT;
        for (int i = 0; i < KW_NUM; i++)
        begin
            w = keyword_word(i);
            packed_w = '0;
            for (int j = 0; j < w.len(); j++)
                packed_w[8*j +: 8] = w[j];
            if (kind == KIND_IDENT && lex_len == 16'(w.len()) && w.len() <= KW_CHARS
                && lex_prefix == packed_w)
                kind = KIND_KEYWORD0 + 5'(i);
        end
        return kind;
    endfunction

    // Emit the token in progress, if any, and go idle
    function automatic void close_pending();
        logic [4:0] kind;
        case (lex_mode)
            SCAN_NUMBER: kind = KIND_NUMBER;
            SCAN_IDENT:  kind = ident_kind();
            SCAN_STRING: kind = KIND_STRING;
            default:     return;
        endcase
        expect_token(kind, lex_start, lex_len, 8'h00, 1'b0);
        lex_mode = SCAN_IDLE;
    endfunction

    function automatic void lex_grow();
        if (lex_len < LEN_CAP)
            lex_len++;
    endfunction

    // Predict the tokens caused by one accepted text transaction
    function automatic void lex_byte(logic [7:0] ch, logic eot);
        logic [15:0] here;
        logic        consumed;
        int          op;
        here = lex_pos;
        consumed = 1'b0;
        op = -1;

        // End of text: flush, emit the end token, start over at position zero
        if (eot || ch == CH_NUL)
        begin
            close_pending();
            expect_token(KIND_END, here, 16'd0, 8'h00, 1'b1);
            lex_mode   = SCAN_IDLE;
            lex_pos    = '0;
            lex_start  = '0;
            lex_len    = '0;
            lex_prefix = '0;
            lex_dot    = 1'b0;
            return;
        end

        // Extend the pending token or close it
        case (lex_mode)
            SCAN_NUMBER:
            begin
                if (is_digit(ch) || (ch == CH_DOT && !lex_dot))
                begin
                    if (ch == CH_DOT)
                        lex_dot = 1'b1;
                    lex_grow();
                    consumed = 1'b1;
                end
                else
                    close_pending();
            end
            SCAN_IDENT:
            begin
                if (is_letter(ch) || is_digit(ch) || ch == CH_USCORE)
                begin
                    if (lex_len < KW_CHARS)
                        lex_prefix = lex_prefix | (40'(ch) << (8 * lex_len));
                    lex_grow();
                    consumed = 1'b1;
                end
                else
                    close_pending();
            end
            SCAN_STRING:
            begin
                if (ch == CH_QUOTE)
                    close_pending();
                else
                    lex_grow();
                consumed = 1'b1;
            end
            default: ;
        endcase

        // Classify a byte that no pending token took
        if (!consumed)
        begin
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR)
                ;
            else if (ch == CH_NL)
                expect_token(KIND_NEWLINE, here, 16'd1, 8'h00, 1'b0);
            else if (is_digit(ch))
            begin
                lex_mode  = SCAN_NUMBER;
                lex_start = here;
                lex_len   = 16'd1;
                lex_dot   = 1'b0;
            end
            else if (is_letter(ch))
            begin
                lex_mode   = SCAN_IDENT;
                lex_start  = here;
                lex_len    = 16'd1;
                lex_prefix = 40'(ch);
            end
            else if (ch == CH_QUOTE)
            begin
                lex_mode  = SCAN_STRING;
                lex_start = here;
                lex_len   = 16'd0;
            end
            else
            begin
                for (int i = 0; i < OP_NUM; i++)
                    if (OP_TEXT[8*(OP_NUM-1-i) +: 8] == ch)
                        op = i;
                if (op >= 0)
                    expect_token(KIND_OP0 + 5'(op), here, 16'd1, 8'h00, 1'b0);
                else
                    expect_token(KIND_UNKNOWN, here, 16'd1, ch, 1'b0);
            end
        end

        if (lex_pos < POS_CAP)
            lex_pos++;
    endfunction

    function automatic string token_text(token_t t);
        return $sformatf("kind=%0d start=%0d len=%0d byte=%02h last=%0b",
                         t.kind, t.start, t.len, t.ubyte, t.last);
    endfunction

    task automatic report_token(string what, token_t want, token_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected %s, got %s", what, token_text(want), token_text(got));
    endtask

    task automatic push_char(logic [7:0] ch);
        text_item_t item;
        item.ch  = ch;
        item.eot = 1'b0;
        pending_q.insert(pending_q.size(), item);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // End of text; the byte rides along and must be ignored
    task automatic push_text_end(logic [7:0] junk);
        text_item_t item;
        item.ch  = junk;
        item.eot = 1'b1;
        pending_q.insert(pending_q.size(), item);
    endtask

    function automatic logic [7:0] random_ident_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range("a", "z"));
            1:       return 8'($urandom_range("A", "Z"));
            2:       return 8'($urandom_range("0", "9"));
            default: return CH_USCORE;
        endcase
    endfunction

    // Append the bytes of one random lexeme
    task automatic push_lexeme();
        string w;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                w = keyword_word($urandom_range(0, KW_NUM - 1));
                case ($urandom_range(0, 3))
                    0: push_text(w.substr(0, w.len() - 2));
                    1:
                    begin
                        push_text(w);
                        push_char(random_ident_char());
                    end
                    default: push_text(w);
                endcase
            end
            2:
            begin
                if ($urandom_range(0, 1) == 0)
                    push_char(8'($urandom_range("a", "z")));
                else
                    push_char(8'($urandom_range("A", "Z")));
                repeat ($urandom_range(0, 8))
                    push_char(random_ident_char());
            end
            3:
            begin
                repeat ($urandom_range(1, 4))
                    push_char(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 1) == 0)
                begin
                    push_char(CH_DOT);
                    repeat ($urandom_range(0, 3))
                        push_char(8'($urandom_range("0", "9")));
                    if ($urandom_range(0, 4) == 0)
                    begin
                        push_char(CH_DOT);
                        push_char(8'($urandom_range("0", "9")));
                    end
                end
            end
            4:
            begin
                push_char(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                    push_char(8'($urandom_range(CH_QUOTE + 1, 255)));
                if ($urandom_range(0, 7) != 0)
                    push_char(CH_QUOTE);
            end
            5, 6: push_char(OP_TEXT[8*$urandom_range(0, OP_NUM - 1) +: 8]);
            7:    push_char(CH_NL);
            8:
            begin
                if ($urandom_range(0, 1) == 0)
                    push_char(8'($urandom_range(128, 255)));
                else
                    push_char(8'($urandom_range(1, 127)));
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       push_char(CH_TAB);
                    1:       push_char(CH_CR);
                    default: push_char(CH_SPACE);
                endcase
            end
        endcase
    endtask

    // Fill the stimulus queue: short directed texts, one long text, then random texts
    initial
    begin
        int unsigned base;

        // Second dot, flush of a number at end of text
        push_text("1.2.3");
        push_text_end(8'h5A);
        // Identifier ended by an operator, skipped blanks, unterminated string with newline
        push_text("ab_9+");
        push_char(CH_SPACE);
        push_char(CH_TAB);
        push_char(CH_CR);
        push_char(CH_QUOTE);
        push_char("x");
        push_char(CH_NL);
        push_char(CH_NUL);
        // High bytes, keyword followed by an operator, end with nothing pending
        push_char(8'hFF);
        push_char(8'h80);
        push_text("let;");
        push_text_end(8'hFF);

        // Long string of high and printable bytes
        push_char(CH_QUOTE);
        repeat (LONG_STRING)
            push_char(8'($urandom_range(CH_QUOTE + 1, 255)));
        push_char(CH_QUOTE);
        push_text("x=1.5");
        push_char(CH_NL);
        push_text_end(8'($urandom_range(0, 255)));

        // Random texts, mostly well formed, some noise
        base = pending_q.size();
        while (pending_q.size() - base < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    push_char(8'($urandom_range(1, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    push_lexeme();
                    if ($urandom_range(0, 2) != 0)
                        push_char(CH_SPACE);
                end
            end
            if ($urandom_range(0, 3) == 0)
                push_char(CH_NUL);
            else
                push_text_end(8'($urandom_range(0, 255)));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all text accepted, all tokens seen, then a quiet spell
        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (token_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && token_expect_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Drive text in bursts and the token ready on its own pattern
    always @(negedge clk)
    begin : text_driver
        text_item_t item;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left != 0 || pending_q.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                item = pending_q.pop_front();
                in_valid <= 1'b1;
                in_byte  <= item.ch;
                in_eot   <= item.eot;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end

        // Switch the stall pattern whenever the low seven bits of ready_tick wrap to zero
        ready_tick <= ready_tick + 1;
        if (ready_tick[6:0] == 7'd0)
            rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
        case (rx_pattern)
            RX_OPEN:   out_ready <= 1'b1;
            RX_SPARSE: out_ready <= (ready_tick[1:0] != 2'd3);
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= (ready_tick[3:0] > 4'd4);
        endcase
    end

    // Check each token transaction, then predict from each text transaction
    always @(posedge clk)
    begin : token_monitor
        token_t got;
        token_t want;
        if (rst_n && token_ch.valid && out_ready)
        begin
            got.kind  = token_ch.token_kind;
            got.start = token_ch.start_pos;
            got.len   = token_ch.value_len;
            got.ubyte = token_ch.unknown_byte;
            got.last  = token_ch.last;
            if (token_expect_q.size() == 0)
                report_token("unexpected token", '0, got);
            else
            begin
                want = token_expect_q.pop_front();
                if (got.kind !== want.kind || got.start !== want.start
                    || got.len !== want.len || got.ubyte !== want.ubyte
                    || got.last !== want.last)
                    report_token("token mismatch", want, got);
            end
        end
        if (rst_n && in_valid && text_ch.ready)
            lex_byte(in_byte, in_eot);
        in_taken <= rst_n && in_valid && text_ch.ready;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule

[script_lexer_token_stream.f]
sv/slt_pkg.sv
sv/slt_if.sv
sv/slt_scan.sv
sv/slt_outq.sv
sv/script_lexer_token_stream.sv
tb/testbench.sv
